// File: src/avm7s_pkg.sv
// Shared types and constants for the averaging voltmeter with seven-segment scan.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package avm7s_pkg;

  // Field widths
  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = 16;
  localparam int SCALE_W  = 9;
  localparam int PROD_W   = SUM_W + SCALE_W;
  localparam int DIGIT_W  = 4;
  localparam int DIGITS   = 4;
  localparam int POS_W    = 2;

  // Scaling: hundredths = floor(sum * 500 / (342 * batch))
  localparam logic [SCALE_W-1:0] SCALE_MUL = 9'd500;
  localparam int                 VOLT_DIV  = 342;
  localparam int                 DEC_BASE  = 10;

  // Scan position that carries the decimal point
  localparam logic [POS_W-1:0] DP_POS = 2'd2;

  // Request codes on the input channel
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [DIGITS-1:0] digit_enable;
    logic [7:0]        segments;
  } out_item_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TICK   = 1'b1
  } item_kind_t;

  // Entry of the queue between front and back
  typedef struct packed {
    item_kind_t          kind;
    logic [SAMPLE_W-1:0] sample;
  } queue_item_t;

  // Common-anode, active-low segment code; codes above nine blank the digit
  function automatic logic [7:0] seg_code(input logic [DIGIT_W-1:0] d);
    logic [7:0] code;
    unique case (d)
      4'd0:    code = 8'hc0;
      4'd1:    code = 8'hf9;
      4'd2:    code = 8'ha4;
      4'd3:    code = 8'hb0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hf8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = 8'hff;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: src/averaging_voltmeter_seven_segment_top.sv
// An accepted scan tick is queued; its transaction is registered into the output when the back end takes it.
// Throughput: one transaction per cycle while no conversion is running and, for a
// tick, the output is free; a sample that closes a batch makes the back end hold
// the queue while the sum is scaled and then split digit by digit by compare-subtract.
// Reset (rst, synchronous) clears the sum, count, scan position, digits
// (display 00.00) and the queue.
`default_nettype none

module averaging_voltmeter_seven_segment_top #(
  parameter int BATCH_SAMPLES = 40
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  avm7s_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output avm7s_pkg::out_item_t  out_data
);
  import avm7s_pkg::*;

  logic        q_valid;
  logic        q_take;
  queue_item_t q_item;

  avm7s_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_take   (q_take)
  );

  avm7s_back #(
    .BATCH_SAMPLES (BATCH_SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: src/avm7s_front.sv
// Front end: accepts input transactions, classifies them and queues them.
// Depends on avm7s_pkg for the item and queue entry types.
`default_nettype none

module avm7s_front (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  avm7s_pkg::in_item_t    in_data,
  output logic                   q_valid,
  output avm7s_pkg::queue_item_t q_item,
  input  wire                    q_take
);
  import avm7s_pkg::*;

  localparam int QDEPTH = 2;

  queue_item_t      entries [QDEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;
  queue_item_t      classified;

  // Classify the incoming transaction
  always_comb begin
    classified.kind   = (in_data.req_type == REQ_TICK) ? KIND_TICK : KIND_SAMPLE;
    classified.sample = in_data.sample;
  end

  assign in_stall = (count == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_take && q_valid;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rd_ptr];

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/avm7s_conv.sv
// Batch-end conversion: scales the sum to hundredths of a volt and splits it
// into decimal digits by compare-subtract, one digit per cycle. Uses avm7s_pkg.
`default_nettype none

module avm7s_conv #(
  parameter int BATCH_SAMPLES = 40
) (
  input  wire                                                    clk,
  input  wire                                                    rst,
  input  wire                                                    start,
  input  wire  [avm7s_pkg::SUM_W-1:0]                            sum,
  output logic                                                   busy,
  output logic [avm7s_pkg::DIGITS-1:0][avm7s_pkg::DIGIT_W-1:0]   digits
);
  import avm7s_pkg::*;

  localparam int               DIVISOR   = VOLT_DIV * BATCH_SAMPLES;
  localparam int               WORK_W    = 32;
  localparam logic [POS_W-1:0] TOP_PLACE = POS_W'(DIGITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIGIT
  } state_t;

  state_t              state;
  logic [POS_W-1:0]    place;
  logic [SUM_W-1:0]    held_sum;
  logic [WORK_W-1:0]   rest;

  logic [DIGIT_W-1:0]  digit_val;
  logic [WORK_W-1:0]   digit_sub;

  // Scaled weight of mult counts of the digit at place p
  function automatic logic [WORK_W-1:0] place_step(input logic [POS_W-1:0] p,
                                                   input int mult);
    int weight;
    case (p)
      2'd0:    weight = mult * DIVISOR;
      2'd1:    weight = mult * DIVISOR * DEC_BASE;
      2'd2:    weight = mult * DIVISOR * DEC_BASE * DEC_BASE;
      default: weight = mult * DIVISOR * DEC_BASE * DEC_BASE * DEC_BASE;
    endcase
    return WORK_W'(weight);
  endfunction

  // Pick the largest digit whose scaled weight still fits the remainder
  always_comb begin
    digit_val = '0;
    digit_sub = '0;
    for (int j = 1; j < DEC_BASE; j++) begin
      if (rest >= place_step(place, j)) begin
        digit_val = DIGIT_W'(j);
        digit_sub = place_step(place, j);
      end
    end
  end

  assign busy = (state != ST_IDLE);

  // Capture the sum, scale it, then peel digits from the top place down
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      place  <= TOP_PLACE;
      digits <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            held_sum <= sum;
            state    <= ST_MUL;
          end
        end
        ST_MUL: begin
          rest  <= WORK_W'(PROD_W'(held_sum) * PROD_W'(SCALE_MUL));
          place <= TOP_PLACE;
          state <= ST_DIGIT;
        end
        ST_DIGIT: begin
          rest          <= rest - digit_sub;
          digits[place] <= digit_val;
          place         <= place - POS_W'(1);
          if (place == '0) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/avm7s_back.sv
// Back end: accumulates samples, starts the conversion at batch end and
// drives one scan transaction per tick. Uses avm7s_pkg and avm7s_conv.
`default_nettype none

module avm7s_back #(
  parameter int BATCH_SAMPLES = 40
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    q_valid,
  input  avm7s_pkg::queue_item_t q_item,
  output logic                   q_take,
  output logic                   out_valid,
  input  wire                    out_stall,
  output avm7s_pkg::out_item_t   out_data
);
  import avm7s_pkg::*;

  localparam int           CW        = $clog2(BATCH_SAMPLES + 1);
  localparam logic [CW:0]  BATCH_END = (CW + 1)'(BATCH_SAMPLES);

  logic [SUM_W-1:0]                   sample_sum;
  logic [CW-1:0]                      sample_count;
  logic [POS_W-1:0]                   scan_position;
  logic [DIGITS-1:0][DIGIT_W-1:0]     shown_digits;

  logic                               conv_busy;
  logic                               conv_start;
  logic                               is_tick;
  logic                               out_free;
  logic                               take_sample;
  logic                               take_tick;
  logic [SUM_W-1:0]                   sum_next;
  logic [CW:0]                        count_inc;
  logic                               batch_done;
  logic [7:0]                         seg_next;

  avm7s_conv #(
    .BATCH_SAMPLES (BATCH_SAMPLES)
  ) u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (conv_start),
    .sum    (sum_next),
    .busy   (conv_busy),
    .digits (shown_digits)
  );

  // Pick the head of the queue when the digits are settled and, for a tick,
  // when the output register can take it
  always_comb begin
    is_tick     = (q_item.kind == KIND_TICK);
    out_free    = !out_valid || !out_stall;
    q_take      = q_valid && !conv_busy && (!is_tick || out_free);
    take_sample = q_take && !is_tick;
    take_tick   = q_take && is_tick;
    sum_next    = sample_sum + SUM_W'(q_item.sample);
    count_inc   = {1'b0, sample_count} + (CW + 1)'(1);
    batch_done  = (count_inc == BATCH_END);
    conv_start  = take_sample && batch_done;
    seg_next    = seg_code(shown_digits[scan_position]);
    if (scan_position == DP_POS) begin
      seg_next[7] = 1'b0;
    end
  end

  // Accumulate samples; clear at batch end
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (take_sample) begin
      if (batch_done) begin
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sum_next;
        sample_count <= count_inc[CW-1:0];
      end
    end
  end

  // Drive the scan transaction and advance the position
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      scan_position <= '0;
    end else begin
      if (take_tick) begin
        out_valid     <= 1'b1;
        scan_position <= scan_position + POS_W'(1);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_tick) begin
      out_data.digit_enable <= ~(DIGITS'(1) << scan_position);
      out_data.segments     <= seg_next;
    end
  end

  // Nothing leaves the queue while the digits are being rewritten
  assert property (@(posedge clk) disable iff (rst) conv_busy |-> !q_take)
    else $error("queue drained during conversion");

  // A conversion starts only from an accepted sample
  assert property (@(posedge clk) disable iff (rst) conv_start |-> (q_take && !is_tick))
    else $error("conversion started without a sample");

  // Starting a conversion makes it busy on the next cycle
  assert property (@(posedge clk) disable iff (rst) conv_start |=> conv_busy)
    else $error("conversion did not start");

  // An accepted tick yields a result on the next cycle
  assert property (@(posedge clk) disable iff (rst) take_tick |=> out_valid)
    else $error("tick lost");

  // The batch counter never reaches the batch size
  assert property (@(posedge clk) disable iff (rst)
                   ({1'b0, sample_count} != BATCH_END))
    else $error("batch counter overran");

endmodule

`default_nettype wire

// File: tb/tb_averaging_voltmeter_seven_segment_top.sv
// Self-checking bench for the averaging voltmeter with multiplexed seven-segment scan.
// Predicts each scan transaction from the sample/tick stream and compares field by field.
// Depends on avm7s_pkg and averaging_voltmeter_seven_segment_top.
module tb_averaging_voltmeter_seven_segment_top;
  import avm7s_pkg::*;

  localparam int BATCH        = 40;
  localparam int ITEM_GOAL    = 1600;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 150;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  averaging_voltmeter_seven_segment_top #(
    .BATCH_SAMPLES(BATCH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Common-anode codes for 0..9; anything above nine blanks the digit
  logic [7:0] seg_lut [16] = '{8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
                               8'h80, 8'h90, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};

  // Meter state as seen by the prediction
  logic [SUM_W-1:0]   meter_sum   = '0;
  int unsigned        meter_count = 0;
  logic [DIGIT_W-1:0] meter_digits [DIGITS] = '{default: '0};
  logic [POS_W-1:0]   meter_pos   = '0;

  in_item_t  queued_requests [$];
  out_item_t due_readouts [$];
  int        gen_count      = 0;
  int        total_requests = 0;
  int        accepted_count = 0;
  int        fail_count     = 0;
  int        hold_left      = 0;
  logic      hold_done      = 1'b0;

  // Fold one accepted request into the meter state; a tick yields one readout
  function automatic void track_reading(in_item_t req);
    int unsigned hundredths;
    out_item_t   shown;
    if (req.req_type == REQ_SAMPLE) begin
      meter_sum = meter_sum + SUM_W'(req.sample);
      meter_count++;
      if (meter_count >= BATCH) begin
        hundredths = (32'(meter_sum) * 32'd500) / (32'd342 * BATCH);
        meter_digits[0] = DIGIT_W'(hundredths % 10);
        meter_digits[1] = DIGIT_W'((hundredths / 10) % 10);
        meter_digits[2] = DIGIT_W'((hundredths / 100) % 10);
        meter_digits[3] = DIGIT_W'(hundredths / 1000);
        meter_sum   = '0;
        meter_count = 0;
      end
    end else begin
      shown.digit_enable = ~(4'b0001 << meter_pos);
      shown.segments     = seg_lut[meter_digits[meter_pos]];
      if (meter_pos == DP_POS) begin
        shown.segments[7] = 1'b0;
      end
      due_readouts.push_back(shown);
      meter_pos = meter_pos + 1'b1;
    end
  endfunction

  // Load phase: 0 slow receiver, 1 slow sender, 2 no idling
  function automatic int load_phase();
    int ph;
    if (total_requests == 0) begin
      return 0;
    end
    ph = accepted_count * 3 / total_requests;
    return (ph > 2) ? 2 : ph;
  endfunction

  function automatic int sender_idle_pct(int ph);
    return (ph == 0) ? 26 : (ph == 1) ? 60 : 0;
  endfunction

  function automatic int receiver_stall_pct(int ph);
    return (ph == 0) ? 60 : (ph == 1) ? 26 : 0;
  endfunction

  task automatic queue_tick(logic [SAMPLE_W-1:0] junk);
    in_item_t req;
    req.req_type = REQ_TICK;
    req.sample   = junk;
    queued_requests.push_back(req);
  endtask

  // Queue a sample; after each full batch show the new reading a few times
  task automatic queue_sample(logic [SAMPLE_W-1:0] value);
    in_item_t req;
    req.req_type = REQ_SAMPLE;
    req.sample   = value;
    queued_requests.push_back(req);
    gen_count++;
    if (gen_count == BATCH) begin
      gen_count = 0;
      repeat (4 + $urandom_range(4)) queue_tick(SAMPLE_W'($urandom));
    end
  endtask

  // Build the stimulus, release reset, wait for the drain, report
  initial begin : stimulus
    int                  batch_idx;
    int                  style;
    logic [SAMPLE_W-1:0] value;
    // Reset display on every position, tick payload ignored
    queue_tick('0);
    queue_tick('1);
    queue_tick(10'h2aa);
    queue_tick(10'h155);
    // Sample extremes and alternating bit patterns
    queue_sample('0);
    queue_sample('1);
    queue_sample(10'h2aa);
    queue_sample(10'h155);
    queue_tick(SAMPLE_W'($urandom));

    // Whole batches with random content and ticks mixed in
    batch_idx = 0;
    while (queued_requests.size() < ITEM_GOAL) begin
      style = (batch_idx == 1) ? 0 : (batch_idx == 2) ? 1 : $urandom_range(5);
      do begin
        if ($urandom_range(3) == 0) begin
          queue_tick(SAMPLE_W'($urandom));
        end
        case (style)
          0: value = '1;
          1: value = '0;
          2: value = SAMPLE_W'($urandom_range(63));
          3: value = SAMPLE_W'($urandom_range(1023, 960));
          default: value = SAMPLE_W'($urandom);
        endcase
        queue_sample(value);
      end while (gen_count != 0);
      batch_idx++;
    end
    total_requests = queued_requests.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (queued_requests.size() != 0 || in_valid) @(posedge clk);
    while (due_readouts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("averaging_voltmeter_seven_segment_top verification clean");
    end else begin
      $display("averaging_voltmeter_seven_segment_top verification failed");
    end
    $finish;
  end

  // Drive requests; a stalled transaction holds its payload
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_reading(in_data);
        accepted_count <= accepted_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (queued_requests.size() != 0 &&
            $urandom_range(99) >= sender_idle_pct(load_phase())) begin
          in_data  <= queued_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random per phase, plus one long hold-off in the last phase
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && load_phase() == 2) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct(load_phase()));
    end
  end

  // Check each accepted scan transaction against the oldest prediction
  always @(posedge clk) begin : scan_check
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_readouts.size() == 0) begin
        $error("unexpected transaction: digit_enable %h segments %h",
               out_data.digit_enable, out_data.segments);
        fail_count++;
      end else begin
        want = due_readouts.pop_front();
        if (out_data.digit_enable !== want.digit_enable) begin
          $error("digit_enable: expected %h, got %h", want.digit_enable,
                 out_data.digit_enable);
          fail_count++;
        end
        if (out_data.segments !== want.segments) begin
          $error("segments: expected %h, got %h", want.segments, out_data.segments);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("averaging_voltmeter_seven_segment_top verification failed");
    $finish;
  end

endmodule
